// File: rtl/qpht_pkg.sv
// shared types and constants for the quadratic probe hash table
// no dependencies; used by the controller, datapath and top level
package qpht_pkg;

  localparam int unsigned KeyW = 31;

  // key is reduced modulo the table size a nibble at a time
  localparam int unsigned HashBits   = 4;
  localparam int unsigned HashCycles = 8;
  localparam int unsigned HashCntW   = 3;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // slot state codes
  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_USED    = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]      op;
    logic [KeyW-1:0] key;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_index;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic hash_step;
    logic issue;
    logic finish;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic hash_last;
    logic done;
  } sts_t;

endpackage

// File: rtl/quadratic_probe_hash_table_core.sv
// top level of the quadratic probe hash table
// depends on qpht_pkg, qpht_ctrl and qpht_datapath
//
// usage:
//   input channel in_valid_i / in_stall_o / in_data_i carries one operation
//   per beat (insert, delete or search of a 31-bit key); output channel
//   out_valid_o / out_stall_i / out_data_o returns one beat per operation
//   with a status and a slot index, in order
//   the key is reduced modulo TABLE_SIZE four bits a cycle, then
//   slots are probed at home + i*i, one registered memory read per cycle,
//   so a probe is judged in the cycle after it is issued
//   an accepted operation passes through the hash steps, a walk of at
//   most TABLE_SIZE probes, the result register and the output register;
//   one operation is in flight at a time and the next beat is taken in the
//   cycle after the result is loaded
//   unused op codes and full-table inserts finish without probing
//   after reset a clearing pass marks every slot empty, with in_stall_o
//   high; while the receiver stalls the next operation is still taken and
//   worked on, waiting at the end for the output register
module quadratic_probe_hash_table_core #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  qpht_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qpht_pkg::out_t out_data_o
);

  qpht_pkg::cmd_t cmd;
  qpht_pkg::sts_t sts;

  // sequencing and handshakes
  qpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // slot memory, hashing, probe walk and result register
  qpht_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: rtl/qpht_ctrl.sv
// sequencing state machine of the quadratic probe hash table
// depends on qpht_pkg; drives the datapath through qpht_pkg::cmd_t
module qpht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  qpht_pkg::sts_t sts_i,
  output qpht_pkg::cmd_t cmd_o
);

  qpht_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qpht_pkg::S_CLEAR: begin
        if (sts_i.clear_last) state_d = qpht_pkg::S_IDLE;
      end
      qpht_pkg::S_IDLE: begin
        if (in_valid_i) state_d = qpht_pkg::S_HASH;
      end
      qpht_pkg::S_HASH: begin
        if (sts_i.hash_last) state_d = qpht_pkg::S_PROBE;
      end
      qpht_pkg::S_PROBE: begin
        if (sts_i.done) state_d = qpht_pkg::S_DONE;
      end
      qpht_pkg::S_DONE: begin
        if (out_free) state_d = qpht_pkg::S_IDLE;
      end
      default: state_d = qpht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      qpht_pkg::S_CLEAR: cmd_o.clear = 1'b1;
      qpht_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      qpht_pkg::S_HASH:  cmd_o.hash_step = 1'b1;
      qpht_pkg::S_PROBE: begin
        cmd_o.issue  = 1'b1;
        cmd_o.finish = sts_i.done;
      end
      qpht_pkg::S_DONE:  cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qpht_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/qpht_datapath.sv
// slot memory, key reduction, probe address generation and result register
// depends on qpht_pkg; steered by qpht_ctrl through qpht_pkg::cmd_t
module qpht_datapath #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qpht_pkg::cmd_t cmd_i,
  output qpht_pkg::sts_t sts_o,
  input  qpht_pkg::in_t  in_data_i,
  output qpht_pkg::out_t out_data_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_SIZE);
  localparam int unsigned CntW  = $clog2(TABLE_SIZE + 1);
  localparam int unsigned WordW = qpht_pkg::KeyW + 2;
  localparam int unsigned PadW  = qpht_pkg::HashBits * qpht_pkg::HashCycles;
  localparam logic [IdxW:0] NExt = (IdxW + 1)'(TABLE_SIZE);

  // slot memory: {slot state, key}
  logic [WordW-1:0] mem [TABLE_SIZE];

  logic [1:0]                  op_q;
  logic [qpht_pkg::KeyW-1:0]   key_q;
  logic [PadW-1:0]             key_sh_q;
  logic [qpht_pkg::HashCntW-1:0] hcnt_q;
  logic [IdxW-1:0]             rem_q, rem_d;
  logic [IdxW-1:0]             pos_q, pos_d;
  logic [IdxW-1:0]             step_q, step_d;
  logic [CntW-1:0]             iss_q;
  logic [WordW-1:0]            rdata_q;
  logic [IdxW-1:0]             rd_pos_q;
  logic                        rd_vld_q;
  logic                        rd_last_q;
  logic [IdxW-1:0]             clr_q;
  logic [CntW-1:0]             cnt_q;
  qpht_pkg::out_t              res_q, res_d;
  qpht_pkg::out_t              out_q;

  logic [1:0]                  rd_state;
  logic [qpht_pkg::KeyW-1:0]   rd_key;
  logic                        can_issue;
  logic                        quick;
  logic                        hit;
  logic                        stop;
  logic [IdxW+3:0]             idx_ext;
  logic                        we;
  logic [IdxW-1:0]             waddr;
  logic [WordW-1:0]            wdata;
  logic                        cnt_inc, cnt_dec;

  // remainder update for a hash step, folding in the top HashBits key bits one bit at a time
  always_comb begin
    logic [IdxW:0] t;
    logic [IdxW-1:0] r;
    logic [qpht_pkg::HashBits-1:0] nib;
    r   = rem_q;
    nib = key_sh_q[PadW-1 -: qpht_pkg::HashBits];
    t   = '0;
    for (int b = qpht_pkg::HashBits - 1; b >= 0; b--) begin
      t = {r, nib[b]};
      if (t >= NExt) t = t - NExt;
      r = t[IdxW-1:0];
    end
    rem_d = r;
  end

  // next probe: pos += 2i+1, step += 2, both modulo the table size
  always_comb begin
    logic [IdxW:0] ps, ss;
    ps = {1'b0, pos_q} + {1'b0, step_q};
    if (ps >= NExt) ps = ps - NExt;
    ss = {1'b0, step_q} + (IdxW + 1)'(2);
    if (ss >= NExt) ss = ss - NExt;
    pos_d  = ps[IdxW-1:0];
    step_d = ss[IdxW-1:0];
  end

  assign can_issue = iss_q < CntW'(TABLE_SIZE);
  assign rd_state  = rdata_q[WordW-1 -: 2];
  assign rd_key    = rdata_q[qpht_pkg::KeyW-1:0];

  // unused op code, or insert into a full table, needs no probing
  assign quick = (op_q != qpht_pkg::OP_INSERT && op_q != qpht_pkg::OP_DELETE &&
                  op_q != qpht_pkg::OP_SEARCH) ||
                 (op_q == qpht_pkg::OP_INSERT && cnt_q >= CntW'(TABLE_SIZE));

  always_comb begin
    hit  = 1'b0;
    stop = 1'b0;
    if (op_q == qpht_pkg::OP_INSERT) begin
      hit = rd_state != qpht_pkg::SLOT_USED;
    end else begin
      hit  = rd_state == qpht_pkg::SLOT_USED && rd_key == key_q;
      stop = rd_state == qpht_pkg::SLOT_EMPTY;
    end
  end

  assign idx_ext = {4'b0, rd_pos_q};

  always_comb begin
    res_d = '0;
    if (quick) begin
      res_d.status = (op_q == qpht_pkg::OP_INSERT) ? qpht_pkg::ST_FULL : qpht_pkg::ST_MISS;
    end else if (hit) begin
      res_d.status     = qpht_pkg::ST_OK;
      res_d.slot_index = idx_ext[3:0];
    end else begin
      res_d.status = (op_q == qpht_pkg::OP_INSERT) ? qpht_pkg::ST_FULL : qpht_pkg::ST_MISS;
    end
  end

  assign sts_o.done       = quick || (rd_vld_q && (hit || stop || rd_last_q));
  assign sts_o.hash_last  = hcnt_q == qpht_pkg::HashCntW'(qpht_pkg::HashCycles - 1);
  assign sts_o.clear_last = clr_q == IdxW'(TABLE_SIZE - 1);

  // memory write: clearing pass, insert or delete
  always_comb begin
    we      = 1'b0;
    waddr   = rd_pos_q;
    wdata   = {qpht_pkg::SLOT_USED, key_q};
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    if (cmd_i.clear) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = {qpht_pkg::SLOT_EMPTY, {qpht_pkg::KeyW{1'b0}}};
    end else if (cmd_i.finish && !quick && rd_vld_q && hit) begin
      if (op_q == qpht_pkg::OP_INSERT) begin
        we      = 1'b1;
        cnt_inc = 1'b1;
      end else if (op_q == qpht_pkg::OP_DELETE) begin
        we      = 1'b1;
        wdata   = {qpht_pkg::SLOT_DELETED, rd_key};
        cnt_dec = cnt_q != '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.issue && can_issue) begin
      rdata_q   <= mem[pos_q];
      rd_pos_q  <= pos_q;
      rd_last_q <= iss_q == CntW'(TABLE_SIZE - 1);
    end
    if (cmd_i.load) begin
      op_q     <= in_data_i.op;
      key_q    <= in_data_i.key;
      key_sh_q <= PadW'(in_data_i.key);
      rem_q    <= '0;
    end else if (cmd_i.hash_step) begin
      key_sh_q <= key_sh_q << qpht_pkg::HashBits;
      rem_q    <= rem_d;
    end
    if (cmd_i.finish) res_q <= res_d;
    if (cmd_i.out_load) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      cnt_q    <= '0;
      hcnt_q   <= '0;
      pos_q    <= '0;
      step_q   <= '0;
      iss_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + IdxW'(1);
      if (cnt_inc) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (cnt_dec) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (cmd_i.load) begin
        hcnt_q   <= '0;
        iss_q    <= '0;
        rd_vld_q <= 1'b0;
        step_q   <= IdxW'(1);
      end else if (cmd_i.hash_step) begin
        hcnt_q <= hcnt_q + qpht_pkg::HashCntW'(1);
        pos_q  <= rem_d;
      end else if (cmd_i.issue) begin
        rd_vld_q <= can_issue;
        if (can_issue) begin
          pos_q  <= pos_d;
          step_q <= step_d;
          iss_q  <= iss_q + CntW'(1);
        end
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// File: verif/qpht_checker.sv
`timescale 1ns / 1ps
// checker for the quadratic probe hash table core: keeps its own copy of the
// table, predicts each result beat and compares it field by field; uses qpht_pkg
module qpht_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  qpht_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  qpht_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  localparam int Slots = 16;

  logic [qpht_pkg::KeyW-1:0] slot_key   [Slots];
  logic [1:0]                slot_state [Slots];
  int                        occupied;
  int                        fails;
  qpht_pkg::out_t            expected_q [$];

  // one operation on the private table, returns the result it should give
  function automatic qpht_pkg::out_t apply_table_op(qpht_pkg::in_t beat);
    qpht_pkg::out_t res;
    logic [3:0]     pos;
    bit             done;
    res.status     = qpht_pkg::ST_MISS;
    res.slot_index = '0;
    done           = 1'b0;
    case (beat.op)
      qpht_pkg::OP_INSERT: begin
        res.status = qpht_pkg::ST_FULL;
        if (occupied < Slots) begin
          for (int i = 0; i < Slots && !done; i++) begin
            pos = beat.key[3:0] + 4'(i * i);
            if (slot_state[pos] != qpht_pkg::SLOT_USED) begin
              slot_key[pos]   = beat.key;
              slot_state[pos] = qpht_pkg::SLOT_USED;
              occupied++;
              res.status     = qpht_pkg::ST_OK;
              res.slot_index = pos;
              done           = 1'b1;
            end
          end
        end
      end
      qpht_pkg::OP_DELETE, qpht_pkg::OP_SEARCH: begin
        for (int i = 0; i < Slots && !done; i++) begin
          pos = beat.key[3:0] + 4'(i * i);
          if (slot_state[pos] == qpht_pkg::SLOT_EMPTY) begin
            done = 1'b1;
          end else if (slot_state[pos] == qpht_pkg::SLOT_USED &&
                       slot_key[pos] == beat.key) begin
            if (beat.op == qpht_pkg::OP_DELETE) begin
              slot_state[pos] = qpht_pkg::SLOT_DELETED;
              if (occupied > 0) occupied--;
            end
            res.status     = qpht_pkg::ST_OK;
            res.slot_index = pos;
            done           = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    qpht_pkg::out_t want;
    if (!rst_ni) begin
      for (int s = 0; s < Slots; s++) begin
        slot_key[s]   = '0;
        slot_state[s] = qpht_pkg::SLOT_EMPTY;
      end
      occupied = 0;
      fails    = 0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: status %0d, slot_index %0d",
                 out_data_i.status, out_data_i.slot_index);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_data_i.status);
            fails++;
          end
          if (out_data_i.slot_index !== want.slot_index) begin
            $error("slot_index mismatch: expected %0d, actual %0d",
                   want.slot_index, out_data_i.slot_index);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(apply_table_op(in_data_i));
      fail_count_o <= fails;
      pending_o    <= expected_q.size();
    end
  end

endmodule

// File: verif/quadratic_probe_hash_table_core_test.sv
`timescale 1ns / 1ps
// top of the quadratic probe hash table core test: clock, reset, operation
// stimulus and a stalling receiver; uses qpht_pkg, qpht_checker and the core
module quadratic_probe_hash_table_core_test;

  localparam int CycleLimit  = 1000000;
  localparam int RandomItems = 1825;
  localparam int PoolSize    = 24;
  // a little over the worst operation latency at 16 slots
  localparam int DrainCycles = 40;
  localparam int HoldCycles  = 400;

  // op code the block must treat as a no-op miss
  localparam logic [1:0] OpUnused = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_e;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  qpht_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  qpht_pkg::out_t out_data;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int burst_left;

  // keys reused across the run so that searches and deletes find things
  logic [qpht_pkg::KeyW-1:0] key_pool [PoolSize];

  quadratic_probe_hash_table_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  qpht_checker table_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // one beat on the input channel; bursts of random length with random gaps
  // in between, valid only drops at the start of a gap
  task automatic send_beat(input logic [1:0] op, input logic [qpht_pkg::KeyW-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= {op, key};
    @(posedge clk);
    // beat is taken at the first edge where stall is low
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    // the checker's count is registered, so it lags the handshake
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // receiver: stall pattern changes after each random span, with two long
  // hold-offs so the block fills up and pushes back on the sender
  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       tick;
    out_stall <= 1'b0;
    tick = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(32, 256);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (tick == 3000 || tick == 12000) begin
          out_stall <= 1'b1;
          repeat (HoldCycles) @(posedge clk);
          tick += HoldCycles;
        end
        case (mode)
          RX_OPEN:     out_stall <= 1'b0;
          RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_stall <= (tick % 3 == 0);
          default:     out_stall <= 1'b0;
        endcase
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("FAIL quadratic_probe_hash_table_core");
    $finish;
  end

  initial begin : stimulus
    int                        insert_pct;
    int                        roll;
    logic [1:0]                op;
    logic [qpht_pkg::KeyW-1:0] key;
    in_valid   <= 1'b0;
    in_data    <= '0;
    rst_n      <= 1'b0;
    burst_left = 0;
    insert_pct = 45;

    // pool keys: both extremes, then a mix of a few crowded homes and spread ones
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < PoolSize; k++) begin
      if (k % 2 == 0) key_pool[k] = {27'($urandom), 4'($urandom_range(0, 3) * 5)};
      else            key_pool[k] = {27'($urandom), 4'($urandom_range(0, 15))};
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: misses, and the unused op code
    send_beat(qpht_pkg::OP_SEARCH, '0);
    send_beat(qpht_pkg::OP_DELETE, '1);
    send_beat(OpUnused, 31'h5555_5555);
    // all-ones key twice: home slot, then the duplicate one probe further on
    send_beat(qpht_pkg::OP_INSERT, '1);
    send_beat(qpht_pkg::OP_INSERT, '1);
    send_beat(qpht_pkg::OP_SEARCH, '1);
    // delete leaves a tombstone, search must skip it to reach the duplicate
    send_beat(qpht_pkg::OP_DELETE, '1);
    send_beat(qpht_pkg::OP_SEARCH, '1);
    // insert with the same home reuses the tombstone
    send_beat(qpht_pkg::OP_INSERT, 31'd15);
    // fill every remaining slot
    for (int h = 1; h < 15; h++) send_beat(qpht_pkg::OP_INSERT, qpht_pkg::KeyW'(h));
    // full table: insert refused, search sweeps every probe without a match
    send_beat(qpht_pkg::OP_INSERT, 31'h2AAA_AAAA);
    send_beat(qpht_pkg::OP_SEARCH, 31'h4000_0000);
    drain_results();

    // random part: pool keys mostly, insert share varies so the table swings
    // between nearly empty and full
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 150 == 0) begin
        roll = $urandom_range(0, 2);
        insert_pct = (roll == 0) ? 20 : (roll == 1) ? 45 : 70;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3)                    op = OpUnused;
      else if (roll < 3 + insert_pct)  op = qpht_pkg::OP_INSERT;
      else if ($urandom_range(0, 1))   op = qpht_pkg::OP_DELETE;
      else                             op = qpht_pkg::OP_SEARCH;
      roll = $urandom_range(0, 99);
      key = (roll < 85) ? key_pool[$urandom_range(0, PoolSize - 1)]
                        : qpht_pkg::KeyW'($urandom);
      send_beat(op, key);
      // sender pause until the block has returned everything
      if (n == RandomItems / 2) drain_results();
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS quadratic_probe_hash_table_core");
    end else begin
      $display("FAIL quadratic_probe_hash_table_core");
    end
    $finish;
  end

endmodule
